FILE: src/tcsr_pkg.sv
// Shared types and constants of the triangle column-span rasteriser.
package tcsr_pkg;

    // Tile edge in pixels, 8 to 64. Coordinates keep their 6-bit fields.
    localparam int TILE_SIZE   = 64;
    localparam int COORD_W     = 6;
    localparam int SHADE_W     = 8;
    // Edge coefficients: differences of two coordinates.
    localparam int COEF_W      = COORD_W + 1;
    // Edge constant term: difference of two coordinate products.
    localparam int CONST_W     = 2 * COORD_W + 2;
    localparam int EDGE_W      = 16;
    // Doubled area of a triangle inside the tile stays below 64 * 64.
    localparam int AREA_W      = 2 * COORD_W;
    localparam int SUM_W       = AREA_W + 5;
    localparam int GROUP_W     = 8;
    localparam int GROUP_IDX_W = $clog2(GROUP_W);
    localparam int ROW_GROUPS  = (TILE_SIZE + GROUP_W - 1) / GROUP_W;
    localparam int MASK_W      = ROW_GROUPS * GROUP_W;
    // Depth of the triangle queue, a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(TILE_SIZE - 1);

    typedef struct packed {
        logic [COORD_W-1:0] vertex_a_x;
        logic [COORD_W-1:0] vertex_a_y;
        logic [COORD_W-1:0] vertex_b_x;
        logic [COORD_W-1:0] vertex_b_y;
        logic [COORD_W-1:0] vertex_c_x;
        logic [COORD_W-1:0] vertex_c_y;
        logic [SHADE_W-1:0] shade;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] first_row;
        logic [COORD_W-1:0] last_row;
        logic               empty_column;
        logic [SHADE_W-1:0] green_level;
        logic [SHADE_W-1:0] blue_level;
        logic               last_span;
    } t_out_item;

    // One sub-area as a linear function: kx * x + ky * y + k0.
    typedef struct packed {
        logic signed [COEF_W-1:0]  kx;
        logic signed [COEF_W-1:0]  ky;
        logic signed [CONST_W-1:0] k0;
    } t_line_fn;

    // Everything the column walker needs for one triangle.
    typedef struct packed {
        t_line_fn [2:0]     lines;
        logic [AREA_W-1:0]  total;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
        logic [SHADE_W-1:0] green;
        logic [SHADE_W-1:0] blue;
    } t_tri_desc;

endpackage

FILE: src/triangle_column_span_rasterizer_unit.sv
// Top level of the triangle column-span rasteriser.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_item, one triangle
//   out     | output    | o_out_valid/i_out_stall | o_out_item, one span
//
// A triangle occupies the column walker for max_x - min_x + 1 columns, 1 to 64:
// the walker issues one bounding-box column per cycle unless the output stalls,
// and tests all rows of that column at once. Each triangle passes
// the front end, queue, walker and stages one and two. Reset is synchronous and
// needs no clearing pass. A stall on the output freezes the walker; the front
// end and the two-entry queue keep taking triangles until both are full.
module triangle_column_span_rasterizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcsr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcsr_pkg::t_out_item o_out_item
);
    import tcsr_pkg::*;

    // Front end to queue.
    logic      push;
    logic      full;
    t_tri_desc front_desc;

    // Queue to column walker.
    logic      q_nonempty;
    logic      pop;
    t_tri_desc q_desc;

    // The front end clamps the vertices and derives the three sub-area
    // functions, the doubled area, the bounding box and the colour.
    tcsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .i_full     (full),
        .o_desc     (front_desc)
    );

    // The queue lets the front end take the next triangle while the walker
    // is still busy with the previous one.
    tcsr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_desc     (front_desc),
        .o_full     (full),
        .o_nonempty (q_nonempty),
        .i_pop      (pop),
        .o_desc     (q_desc)
    );

    // The walker moves across the bounding box, left to right, and hands
    // each column through stages one and two to the output register. It
    // pops the next queued triangle in the same cycle as the last column issues.
    tcsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_nonempty),
        .i_q_desc    (q_desc),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: src/tcsr_front.sv
// Front end: takes a triangle, clamps it and prepares its edge functions.
module tcsr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcsr_pkg::t_in_item  i_in_item,
    output logic                o_push,
    input  logic                i_full,
    output tcsr_pkg::t_tri_desc o_desc
);
    import tcsr_pkg::*;

    logic               r_valid;
    logic [COORD_W-1:0] r_vx [3];
    logic [COORD_W-1:0] r_vy [3];
    logic [SHADE_W-1:0] r_shade;
    logic               accept;

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    assign o_in_stall = r_valid && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vx[0] <= clamp(i_in_item.vertex_a_x);
            r_vy[0] <= clamp(i_in_item.vertex_a_y);
            r_vx[1] <= clamp(i_in_item.vertex_b_x);
            r_vy[1] <= clamp(i_in_item.vertex_b_y);
            r_vx[2] <= clamp(i_in_item.vertex_c_x);
            r_vy[2] <= clamp(i_in_item.vertex_c_y);
            r_shade <= i_in_item.shade;
        end
    end

    // Sub-area k replaces vertex k by the pixel; q and r are the other two
    // vertices in cyclic order. The constant terms sum to the signed doubled area.
    always_comb begin
        logic [2*COORD_W-1:0]      p_qr;
        logic [2*COORD_W-1:0]      p_rq;
        logic signed [EDGE_W-1:0]  area_sum;
        logic signed [EDGE_W-1:0]  area_abs;
        logic [2*COORD_W+2:0]      g_scaled;
        logic [2*COORD_W+3:0]      g_round;
        int                        q;
        int                        r;
        area_sum = '0;
        for (int k = 0; k < 3; k++) begin
            q    = (k + 1) % 3;
            r    = (k + 2) % 3;
            p_qr = r_vx[q] * r_vy[r];
            p_rq = r_vx[r] * r_vy[q];
            o_desc.lines[k].kx = $signed({1'b0, r_vy[q]}) - $signed({1'b0, r_vy[r]});
            o_desc.lines[k].ky = $signed({1'b0, r_vx[r]}) - $signed({1'b0, r_vx[q]});
            o_desc.lines[k].k0 = $signed({2'b00, p_qr}) - $signed({2'b00, p_rq});
            area_sum = area_sum + EDGE_W'(o_desc.lines[k].k0);
        end
        area_abs     = area_sum[EDGE_W-1] ? -area_sum : area_sum;
        o_desc.total = area_abs[AREA_W-1:0];

        o_desc.min_x = r_vx[0];
        o_desc.max_x = r_vx[0];
        o_desc.min_y = r_vy[0];
        o_desc.max_y = r_vy[0];
        for (int k = 1; k < 3; k++) begin
            if (r_vx[k] < o_desc.min_x) o_desc.min_x = r_vx[k];
            if (r_vx[k] > o_desc.max_x) o_desc.max_x = r_vx[k];
            if (r_vy[k] < o_desc.min_y) o_desc.min_y = r_vy[k];
            if (r_vy[k] > o_desc.max_y) o_desc.max_y = r_vy[k];
        end

        // shade * 128 / 255 through the exact 16-bit reciprocal form.
        g_scaled     = {r_shade, 7'b0};
        g_round      = {1'b0, g_scaled} + (2*COORD_W+4)'(g_scaled >> 8) + 1'b1;
        o_desc.green = g_round[2*COORD_W+3:8];
        o_desc.blue  = r_shade;
    end

endmodule

FILE: src/tcsr_queue.sv
// Short queue of prepared triangles between the front end and the walker.
module tcsr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tcsr_pkg::t_tri_desc i_desc,
    output logic                o_full,
    output logic                o_nonempty,
    input  logic                i_pop,
    output tcsr_pkg::t_tri_desc o_desc
);
    import tcsr_pkg::*;

    t_tri_desc         r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_desc     = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_desc;
    end

endmodule

FILE: src/tcsr_back.sv
// Column walker: one column per cycle unless stalled, all rows tested at once.
module tcsr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tcsr_pkg::t_tri_desc i_q_desc,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcsr_pkg::t_out_item o_out_item
);
    import tcsr_pkg::*;

    typedef struct packed {
        logic               any;
        logic [COORD_W-1:0] first;
        logic [COORD_W-1:0] last;
    } t_span;

    // Walker control.
    logic               r_busy;
    t_tri_desc          r_desc;
    logic [COORD_W-1:0] r_x;
    logic               en;
    logic               issue;
    logic               last_col;

    // Stage one: edge values at row zero of the column.
    logic                     r_s1_valid;
    logic signed [EDGE_W-1:0] r_s1_base [3];
    logic signed [COEF_W-1:0] r_s1_ky [3];
    logic [AREA_W-1:0]        r_s1_total;
    logic [COORD_W-1:0]       r_s1_min_y;
    logic [COORD_W-1:0]       r_s1_max_y;
    logic [COORD_W-1:0]       r_s1_x;
    logic                     r_s1_last;
    logic [SHADE_W-1:0]       r_s1_green;
    logic [SHADE_W-1:0]       r_s1_blue;

    // Stage two: inside mask of the column.
    logic               r_s2_valid;
    logic [MASK_W-1:0]  r_s2_mask;
    logic [COORD_W-1:0] r_s2_x;
    logic               r_s2_last;
    logic [SHADE_W-1:0] r_s2_green;
    logic [SHADE_W-1:0] r_s2_blue;

    logic                     r_o_valid;
    t_out_item                r_o_item;
    logic signed [EDGE_W-1:0] base [3];
    logic [MASK_W-1:0]        row_hit;
    t_span                    span;

    function automatic logic [SUM_W-1:0] edge_mag(
        input logic signed [EDGE_W-1:0] b,
        input logic signed [COEF_W-1:0] ky,
        input logic [COORD_W-1:0]       y
    );
        logic signed [2*COEF_W-1:0] p;
        logic signed [EDGE_W-1:0]   e;
        logic signed [EDGE_W-1:0]   a;
        p = ky * $signed({1'b0, y});
        e = b + EDGE_W'(p);
        a = e[EDGE_W-1] ? -e : e;
        return SUM_W'($unsigned(a));
    endfunction

    // Lowest and highest set bit, first within groups of eight rows and then
    // across the groups.
    function automatic t_span find_span(input logic [MASK_W-1:0] m);
        logic [ROW_GROUPS-1:0]  g_any;
        logic [GROUP_IDX_W-1:0] g_first [ROW_GROUPS];
        logic [GROUP_IDX_W-1:0] g_last [ROW_GROUPS];
        t_span                  s;
        for (int g = 0; g < ROW_GROUPS; g++) begin
            g_any[g]   = |m[g*GROUP_W +: GROUP_W];
            g_first[g] = '0;
            g_last[g]  = '0;
            for (int j = GROUP_W - 1; j >= 0; j--) begin
                if (m[g*GROUP_W + j]) g_first[g] = GROUP_IDX_W'(j);
            end
            for (int j = 0; j < GROUP_W; j++) begin
                if (m[g*GROUP_W + j]) g_last[g] = GROUP_IDX_W'(j);
            end
        end
        s = '0;
        s.any = |g_any;
        for (int g = ROW_GROUPS - 1; g >= 0; g--) begin
            if (g_any[g]) s.first = COORD_W'(g * GROUP_W) + COORD_W'(g_first[g]);
        end
        for (int g = 0; g < ROW_GROUPS; g++) begin
            if (g_any[g]) s.last = COORD_W'(g * GROUP_W) + COORD_W'(g_last[g]);
        end
        return s;
    endfunction

    assign en       = !r_o_valid || !i_out_stall;
    assign issue    = r_busy && en;
    assign last_col = (r_x == r_desc.max_x);
    assign o_pop    = i_q_valid && (!r_busy || (issue && last_col));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (issue && last_col) begin
                r_busy <= 1'b0;
            end
            if (en) begin
                r_s1_valid <= issue;
                r_s2_valid <= r_s1_valid;
                r_o_valid  <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_desc;
            r_x    <= i_q_desc.min_x;
        end else if (issue) begin
            r_x <= r_x + 1'b1;
        end
    end

    always_comb begin
        logic signed [2*COEF_W-1:0] p;
        for (int k = 0; k < 3; k++) begin
            p       = r_desc.lines[k].kx * $signed({1'b0, r_x});
            base[k] = EDGE_W'(p) + EDGE_W'(r_desc.lines[k].k0);
        end
    end

    for (genvar r = 0; r < MASK_W; r++) begin : g_row
        if (r < TILE_SIZE) begin : g_live
            localparam logic [COORD_W-1:0] ROW = COORD_W'(r);
            assign row_hit[r] = (ROW >= r_s1_min_y) && (ROW <= r_s1_max_y)
                && ((edge_mag(r_s1_base[0], r_s1_ky[0], ROW)
                   + edge_mag(r_s1_base[1], r_s1_ky[1], ROW)
                   + edge_mag(r_s1_base[2], r_s1_ky[2], ROW))
                   == SUM_W'(r_s1_total));
        end else begin : g_pad
            assign row_hit[r] = 1'b0;
        end
    end

    assign span = find_span(r_s2_mask);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1_base[k] <= base[k];
                r_s1_ky[k]   <= r_desc.lines[k].ky;
            end
            r_s1_total <= r_desc.total;
            r_s1_min_y <= r_desc.min_y;
            r_s1_max_y <= r_desc.max_y;
            r_s1_x     <= r_x;
            r_s1_last  <= last_col;
            r_s1_green <= r_desc.green;
            r_s1_blue  <= r_desc.blue;

            r_s2_mask  <= row_hit;
            r_s2_x     <= r_s1_x;
            r_s2_last  <= r_s1_last;
            r_s2_green <= r_s1_green;
            r_s2_blue  <= r_s1_blue;

            r_o_item.column       <= r_s2_x;
            r_o_item.first_row    <= span.first;
            r_o_item.last_row     <= span.last;
            r_o_item.empty_column <= !span.any;
            r_o_item.green_level  <= r_s2_green;
            r_o_item.blue_level   <= r_s2_blue;
            r_o_item.last_span    <= r_s2_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

FILE: src/tcsr_checker.sv
// Port-level checks of the rasteriser and their attachment to the top level.
module tcsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tcsr_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tcsr_pkg::t_out_item o_out_item
);
    import tcsr_pkg::*;

    // A stalled span is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled span changed");

    // An empty column reports rows zero.
    a_empty_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.empty_column
        |-> o_out_item.first_row == '0 && o_out_item.last_row == '0)
        else $error("empty column with non-zero rows");

    // A filled column has its first row at or above its last row.
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.empty_column
        |-> o_out_item.first_row <= o_out_item.last_row)
        else $error("first row below last row");

    // Spans of one triangle follow each other column by column, with no gap.
    a_next_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_span
        |=> o_out_valid
            && o_out_item.column == $past(o_out_item.column) + COORD_W'(1))
        else $error("span sequence broken within a triangle");

endmodule

bind triangle_column_span_rasterizer_unit tcsr_checker u_tcsr_checker (.*);
